/* rtl/gdz_pkg.sv */
// ----------------------------------------------------------------------------
// gdz_pkg
// Shared types and constants for the gamepad dead zone and button edge block.
// ----------------------------------------------------------------------------
package gdz_pkg;

    localparam int BUTTON_COUNT_DEF = 15;
    localparam int PAD_COUNT_DEF    = 2;

    localparam int BTN_W   = 15;   // button word width
    localparam int DZ_W    = 15;   // dead zone register width
    localparam logic [DZ_W-1:0] DZ_RESET = 15'd8192;

    localparam int SQ_W    = 32;   // x*x + y*y
    localparam int RAD_W   = 48;   // radicand, sq << 16
    localparam int MAG_W   = 24;   // magnitude, unsigned Q16.8
    localparam int REM_W   = 26;   // root remainder
    localparam int DEN_W   = 40;   // (1 - dz) * mag
    localparam int NUM_W   = 57;   // dividend and shifted divisor
    localparam int QUO_W   = 18;   // quotient bits, wide enough to see overflow before saturation
    localparam int ROOT_STEPS = MAG_W;
    localparam int DIV_STEPS  = QUO_W;

    typedef struct packed {
        logic                in_pad;
        logic signed [15:0]  in_left_x;
        logic signed [15:0]  in_left_y;
        logic signed [15:0]  in_right_x;
        logic signed [15:0]  in_right_y;
        logic signed [15:0]  in_trigger_left;
        logic signed [15:0]  in_trigger_right;
        logic [BTN_W-1:0]    in_buttons;
    } in_t;

    typedef struct packed {
        logic                out_pad;
        logic signed [15:0]  out_left_x;
        logic signed [15:0]  out_left_y;
        logic signed [15:0]  out_right_x;
        logic signed [15:0]  out_right_y;
        logic [14:0]         out_trigger_left;
        logic [14:0]         out_trigger_right;
        logic [BTN_W-1:0]    out_held;
        logic [BTN_W-1:0]    out_pressed;
        logic [BTN_W-1:0]    out_released;
    } out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_DEN,
        OP_NUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_STORE,
        OP_ZERO,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic stick;   // 0 left, 1 right
        logic axis;    // 0 x, 1 y
    } cmd_t;

    typedef struct packed {
        logic below;      // stick inside dead zone or zero magnitude
        logic root_done;
        logic div_done;
    } sts_t;

endpackage

/* rtl/gamepad_deadzone_and_button_edges.sv */
// ----------------------------------------------------------------------------
// gamepad_deadzone_and_button_edges
// Radial dead zone on two sticks, trigger remap and button edge masks.
// ----------------------------------------------------------------------------
//  channel  | ports                          | moves
//  ---------+--------------------------------+---------------------------
//  input    | s_valid, s_ready, s_data       | one controller report
//  result   | m_valid, m_ready, m_data       | one conditioned report
//  config   | cfg_valid, cfg_ready, cfg_data | dead zone radius, Q0.15
//
// m_valid and s_ready rise together when a result is registered, after
// the input has run through the 24-step square root per stick and the
// 18-step divider per axis (skipped for a stick inside the dead zone).
// A new transaction is taken while the previous result waits in m_data;
// its result then holds until that one is taken.
// Reset clears the button history and sets the dead zone to 0.25.
// ----------------------------------------------------------------------------
module gamepad_deadzone_and_button_edges #(
    parameter int BUTTON_COUNT = gdz_pkg::BUTTON_COUNT_DEF,
    parameter int PAD_COUNT    = gdz_pkg::PAD_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gdz_pkg::DZ_W-1:0]  cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  gdz_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output gdz_pkg::out_t             m_data
);

    gdz_pkg::cmd_t cmd;
    gdz_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    gdz_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gdz_dp #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .PAD_COUNT    (PAD_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule

/* rtl/gdz_dp.sv */
// ----------------------------------------------------------------------------
// gdz_dp
// Datapath: multipliers, bit-serial square root, restoring divider,
// trigger remap, per-pad button history and the result register.
// ----------------------------------------------------------------------------
module gdz_dp #(
    parameter int BUTTON_COUNT = gdz_pkg::BUTTON_COUNT_DEF,
    parameter int PAD_COUNT    = gdz_pkg::PAD_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic [gdz_pkg::DZ_W-1:0]  cfg_data,
    input  gdz_pkg::in_t              s_data,
    input  gdz_pkg::cmd_t             cmd,
    output gdz_pkg::sts_t             sts,
    output gdz_pkg::out_t             m_data
);

    localparam int SLOT_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam logic [gdz_pkg::BTN_W-1:0] BTN_MASK = (BUTTON_COUNT >= gdz_pkg::BTN_W) ?
        {gdz_pkg::BTN_W{1'b1}} : gdz_pkg::BTN_W'((32'd1 << BUTTON_COUNT) - 32'd1);

    logic [gdz_pkg::DZ_W-1:0]   dz_reg;
    gdz_pkg::in_t               in_reg;
    logic [gdz_pkg::BTN_W-1:0]  prev_reg [PAD_COUNT];
    logic [gdz_pkg::BTN_W-1:0]  held_reg, pressed_reg, released_reg;
    logic [gdz_pkg::SQ_W-1:0]   sq_reg;
    logic [gdz_pkg::RAD_W-1:0]  rad_reg;
    logic [gdz_pkg::REM_W-1:0]  rem_reg;
    logic [gdz_pkg::MAG_W-1:0]  root_reg;
    logic [4:0]                 rcnt_reg;
    logic                       zero_reg;
    logic [gdz_pkg::DEN_W-1:0]  den_reg;
    logic [gdz_pkg::NUM_W-1:0]  drem_reg, dsh_reg;
    logic [gdz_pkg::QUO_W-1:0]  quo_reg;
    logic [4:0]                 dcnt_reg;
    logic [15:0]                res_reg [4];
    gdz_pkg::out_t              out_reg;

    logic signed [15:0]         axis_val;
    logic [16:0]                mag;
    logic [SLOT_W-1:0]          slot;
    logic [gdz_pkg::BTN_W-1:0]  now_btn, before_btn;
    logic [27:0]                rem_sh, trial;
    logic [15:0]                one_m_dz;
    logic [gdz_pkg::MAG_W-1:0]  mag_diff;
    logic [40:0]                num_p;
    logic [15:0]                res_val;
    logic [1:0]                 res_idx;

    always_comb begin
        case ({cmd.stick, cmd.axis})
            2'b00:   axis_val = in_reg.in_left_x;
            2'b01:   axis_val = in_reg.in_left_y;
            2'b10:   axis_val = in_reg.in_right_x;
            default: axis_val = in_reg.in_right_y;
        endcase
    end

    assign mag      = axis_val[15] ? (17'd0 - {1'b1, axis_val}) : {1'b0, axis_val};
    assign slot     = (PAD_COUNT > 1) ? SLOT_W'(s_data.in_pad) : '0;
    assign now_btn  = s_data.in_buttons & BTN_MASK;
    assign before_btn = prev_reg[slot] & BTN_MASK;
    assign rem_sh   = {rem_reg, rad_reg[gdz_pkg::RAD_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign one_m_dz = 16'(17'd32768 - {2'b00, dz_reg});
    assign mag_diff = root_reg - {1'b0, dz_reg, 8'd0};
    assign num_p    = {24'd0, mag} * {17'd0, mag_diff};
    assign res_idx  = {cmd.stick, cmd.axis};

    // saturate the quotient with the axis sign restored
    always_comb begin
        if (axis_val[15]) begin
            res_val = (quo_reg > 18'd32768) ? 16'h8000 : 16'(18'd0 - quo_reg);
        end else begin
            res_val = (quo_reg > 18'd32767) ? 16'h7fff : quo_reg[15:0];
        end
    end

    assign sts.below     = zero_reg || (root_reg == '0);
    assign sts.root_done = (rcnt_reg == '0);
    assign sts.div_done  = (dcnt_reg == '0);
    assign m_data        = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg   <= gdz_pkg::DZ_RESET;
            rcnt_reg <= '0;
            dcnt_reg <= '0;
            for (int i = 0; i < PAD_COUNT; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                dz_reg <= cfg_data;
            end
            case (cmd.op)
                gdz_pkg::OP_LOAD: begin
                    in_reg         <= s_data;
                    held_reg       <= now_btn;
                    pressed_reg    <= now_btn & ~before_btn;
                    released_reg   <= before_btn & ~now_btn;
                    prev_reg[slot] <= now_btn;
                end
                gdz_pkg::OP_SQ: begin
                    if (cmd.axis) begin
                        sq_reg <= sq_reg + 32'({17'd0, mag} * {17'd0, mag});
                    end else begin
                        sq_reg <= 32'({17'd0, mag} * {17'd0, mag});
                    end
                end
                gdz_pkg::OP_ROOT_INIT: begin
                    rad_reg  <= {sq_reg, 16'd0};
                    rem_reg  <= '0;
                    root_reg <= '0;
                    rcnt_reg <= 5'(gdz_pkg::ROOT_STEPS);
                    zero_reg <= sq_reg < {2'b00, {15'd0, dz_reg} * {15'd0, dz_reg}};
                end
                gdz_pkg::OP_ROOT_STEP: begin
                    if (rem_sh >= trial) begin
                        rem_reg  <= gdz_pkg::REM_W'(rem_sh - trial);
                        root_reg <= {root_reg[gdz_pkg::MAG_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= gdz_pkg::REM_W'(rem_sh);
                        root_reg <= {root_reg[gdz_pkg::MAG_W-2:0], 1'b0};
                    end
                    rad_reg  <= {rad_reg[gdz_pkg::RAD_W-3:0], 2'b00};
                    rcnt_reg <= rcnt_reg - 5'd1;
                end
                gdz_pkg::OP_DEN: begin
                    den_reg <= {24'd0, one_m_dz} * {16'd0, root_reg};
                end
                gdz_pkg::OP_NUM: begin
                    drem_reg <= {1'b0, num_p, 15'd0};
                end
                gdz_pkg::OP_DIV_INIT: begin
                    // add half the divisor for round to nearest
                    drem_reg <= drem_reg + {18'd0, den_reg[gdz_pkg::DEN_W-1:1]};
                    dsh_reg  <= {den_reg, 17'd0};
                    quo_reg  <= '0;
                    dcnt_reg <= 5'(gdz_pkg::DIV_STEPS);
                end
                gdz_pkg::OP_DIV_STEP: begin
                    if (drem_reg >= dsh_reg) begin
                        drem_reg <= drem_reg - dsh_reg;
                        quo_reg  <= {quo_reg[gdz_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        quo_reg  <= {quo_reg[gdz_pkg::QUO_W-2:0], 1'b0};
                    end
                    dsh_reg  <= {1'b0, dsh_reg[gdz_pkg::NUM_W-1:1]};
                    dcnt_reg <= dcnt_reg - 5'd1;
                end
                gdz_pkg::OP_STORE: begin
                    res_reg[res_idx] <= res_val;
                end
                gdz_pkg::OP_ZERO: begin
                    res_reg[{cmd.stick, 1'b0}] <= '0;
                    res_reg[{cmd.stick, 1'b1}] <= '0;
                end
                gdz_pkg::OP_OUT: begin
                    out_reg.out_pad           <= in_reg.in_pad;
                    out_reg.out_left_x        <= res_reg[0];
                    out_reg.out_left_y        <= res_reg[1];
                    out_reg.out_right_x       <= res_reg[2];
                    out_reg.out_right_y       <= res_reg[3];
                    out_reg.out_trigger_left  <= {~in_reg.in_trigger_left[15],
                                                  in_reg.in_trigger_left[14:1]};
                    out_reg.out_trigger_right <= {~in_reg.in_trigger_right[15],
                                                  in_reg.in_trigger_right[14:1]};
                    out_reg.out_held          <= held_reg;
                    out_reg.out_pressed       <= pressed_reg;
                    out_reg.out_released      <= released_reg;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/gdz_ctrl.sv */
// ----------------------------------------------------------------------------
// gdz_ctrl
// Sequencer: steps both sticks through square and root, and outside the
// dead zone scale and divide, then hands the result to the output register.
// ----------------------------------------------------------------------------
module gdz_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  gdz_pkg::sts_t   sts,
    output gdz_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_ROOT_INIT, ST_ROOT_RUN, ST_DEN,
        ST_NUM, ST_DIV_INIT, ST_DIV_RUN, ST_EMIT
    } state_t;

    state_t state_reg;
    logic   stick_reg, axis_reg, m_valid_reg;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd.op    = gdz_pkg::OP_NONE;
        cmd.stick = stick_reg;
        cmd.axis  = axis_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) cmd.op = gdz_pkg::OP_LOAD;
            ST_SQ_X: begin
                cmd.op   = gdz_pkg::OP_SQ;
                cmd.axis = 1'b0;
            end
            ST_SQ_Y: begin
                cmd.op   = gdz_pkg::OP_SQ;
                cmd.axis = 1'b1;
            end
            ST_ROOT_INIT: cmd.op = gdz_pkg::OP_ROOT_INIT;
            ST_ROOT_RUN: begin
                if (!sts.root_done) cmd.op = gdz_pkg::OP_ROOT_STEP;
                else if (sts.below) cmd.op = gdz_pkg::OP_ZERO;
            end
            ST_DEN:       cmd.op = gdz_pkg::OP_DEN;
            ST_NUM:       cmd.op = gdz_pkg::OP_NUM;
            ST_DIV_INIT:  cmd.op = gdz_pkg::OP_DIV_INIT;
            ST_DIV_RUN:   cmd.op = sts.div_done ? gdz_pkg::OP_STORE : gdz_pkg::OP_DIV_STEP;
            ST_EMIT:      if (out_free) cmd.op = gdz_pkg::OP_OUT;
            default:      cmd.op = gdz_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stick_reg   <= 1'b0;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // raise on a new result, drop once the held one is taken
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        stick_reg <= 1'b0;
                        state_reg <= ST_SQ_X;
                    end
                end
                ST_SQ_X:      state_reg <= ST_SQ_Y;
                ST_SQ_Y:      state_reg <= ST_ROOT_INIT;
                ST_ROOT_INIT: state_reg <= ST_ROOT_RUN;
                ST_ROOT_RUN: begin
                    if (sts.root_done) begin
                        if (sts.below) begin
                            // stick zeroed, advance to the next stick or emit
                            stick_reg <= 1'b1;
                            state_reg <= stick_reg ? ST_EMIT : ST_SQ_X;
                        end else begin
                            axis_reg  <= 1'b0;
                            state_reg <= ST_DEN;
                        end
                    end
                end
                ST_DEN:      state_reg <= ST_NUM;
                ST_NUM:      state_reg <= ST_DIV_INIT;
                ST_DIV_INIT: state_reg <= ST_DIV_RUN;
                ST_DIV_RUN: begin
                    if (sts.div_done) begin
                        if (!axis_reg) begin
                            axis_reg  <= 1'b1;
                            state_reg <= ST_NUM;
                        end else begin
                            stick_reg <= 1'b1;
                            state_reg <= stick_reg ? ST_EMIT : ST_SQ_X;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* rtl/gdz_chk.sv */
// ----------------------------------------------------------------------------
// gdz_chk
// Port-level checks for the gamepad conditioner, bound to the top level.
// ----------------------------------------------------------------------------
module gdz_chk (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input gdz_pkg::out_t             m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    a_edges_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.out_pressed & m_data.out_released) == '0))
        else $error("button both pressed and released");

    a_pressed_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.out_pressed & ~m_data.out_held) == '0))
        else $error("pressed button not held");

endmodule

bind gamepad_deadzone_and_button_edges gdz_chk u_chk (.*);

/* bench/gdz_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gdz_checker
// Watches the config, input and result channels of the gamepad conditioner,
// predicts every conditioned report and compares it with the one received.
// ----------------------------------------------------------------------------
module gdz_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [14:0]    cfg_data,
    input  logic           s_valid,
    input  logic           s_ready,
    input  gdz_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  gdz_pkg::out_t  m_data,
    output int             fail_count,
    output int             pending_reports,
    output int             report_count
);

    logic [14:0]   dz_radius;
    logic [14:0]   last_buttons [2];
    gdz_pkg::out_t report_queue [$];

    function automatic logic [47:0] root48(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res[47:0];
    endfunction

    function automatic logic [15:0] scale_axis(input logic signed [15:0] a,
                                               input logic [63:0] m,
                                               input logic [14:0] dz);
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] q;
        mag = (a < 0) ? 64'(-int'(a)) : 64'(int'(a));
        den = (64'd32768 - dz) * m;
        q = (mag * (m - (64'(dz) << 8)) * 64'd32768 + den / 2) / den;
        if (a < 0) return (q > 32768) ? 16'h8000 : 16'(-int'(q));
        return (q > 32767) ? 16'h7fff : q[15:0];
    endfunction

    task automatic dead_zone_stick(input logic signed [15:0] x,
                                   input logic signed [15:0] y,
                                   input logic [14:0] dz,
                                   output logic [15:0] ox,
                                   output logic [15:0] oy);
        logic [63:0] sq;
        logic [63:0] m;
        sq = 64'(int'(x) * int'(x)) + 64'(int'(y) * int'(y));
        ox = 0;
        oy = 0;
        if (sq >= 64'(dz) * dz) begin
            m = 64'(root48(sq << 16));
            if (m != 0) begin
                ox = scale_axis(x, m, dz);
                oy = scale_axis(y, m, dz);
            end
        end
    endtask

    function automatic logic [14:0] map_trigger(input logic signed [15:0] t);
        logic [16:0] s;
        s = 17'(int'(t) + 32768);
        return s[15:1];
    endfunction

    always @(posedge aclk) begin
        gdz_pkg::out_t exp_rep;
        gdz_pkg::out_t got;
        logic [15:0] ax, ay;
        if (!aresetn) begin
            dz_radius <= gdz_pkg::DZ_RESET;
            last_buttons[0] <= '0;
            last_buttons[1] <= '0;
            report_queue.delete();
            fail_count <= 0;
            report_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) dz_radius <= cfg_data;
            if (s_valid && s_ready) begin
                exp_rep.out_pad = s_data.in_pad;
                dead_zone_stick(s_data.in_left_x, s_data.in_left_y, dz_radius, ax, ay);
                exp_rep.out_left_x = ax;
                exp_rep.out_left_y = ay;
                dead_zone_stick(s_data.in_right_x, s_data.in_right_y, dz_radius, ax, ay);
                exp_rep.out_right_x = ax;
                exp_rep.out_right_y = ay;
                exp_rep.out_trigger_left = map_trigger(s_data.in_trigger_left);
                exp_rep.out_trigger_right = map_trigger(s_data.in_trigger_right);
                exp_rep.out_held = s_data.in_buttons;
                exp_rep.out_pressed = s_data.in_buttons & ~last_buttons[s_data.in_pad];
                exp_rep.out_released = ~s_data.in_buttons & last_buttons[s_data.in_pad];
                last_buttons[s_data.in_pad] <= s_data.in_buttons;
                report_queue.push_back(exp_rep);
            end
            if (m_valid && m_ready) begin
                got = m_data;
                report_count <= report_count + 1;
                if (report_queue.size() == 0) begin
                    if (fail_count < 10) $display("unexpected report %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_rep = report_queue.pop_front();
                    if (got !== exp_rep) begin
                        if (fail_count < 10)
                            $display("report mismatch: expected %h got %h", exp_rep, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_reports <= report_queue.size();
    end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives controller reports and dead zone settings into the conditioner,
// with random idling on both channels, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 2000000;

    logic          aclk;
    logic          aresetn;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [14:0]   cfg_data;
    logic          s_valid;
    logic          s_ready;
    gdz_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    gdz_pkg::out_t m_data;
    int            fail_count;
    int            pending_reports;
    int            report_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            cycle_count;

    gamepad_deadzone_and_button_edges uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    gdz_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_reports(pending_reports),
        .report_count(report_count)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d reports outstanding", pending_reports);
            $display("[gamepad_deadzone_and_button_edges] ERROR");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_report(input gdz_pkg::in_t rep);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1;
        s_data <= rep;
        do @(posedge aclk); while (!s_ready);
        // drop valid after the handshake; the block is busy then anyway
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic write_dead_zone(input logic [14:0] dz);
        while (pending_reports != 0) @(posedge aclk);
        // let the block drain a transaction still in flight
        repeat (200) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= dz;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(4000)) - 16'sd2000;
            3: return 16'($urandom_range(20000)) - 16'sd10000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic gdz_pkg::in_t random_report();
        gdz_pkg::in_t r;
        r.in_pad = 1'($urandom_range(1));
        r.in_left_x = pick_axis();
        r.in_left_y = pick_axis();
        r.in_right_x = pick_axis();
        r.in_right_y = pick_axis();
        r.in_trigger_left = pick_axis();
        r.in_trigger_right = pick_axis();
        r.in_buttons = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(7));
        return r;
    endfunction

    initial begin
        gdz_pkg::in_t rep;
        logic [14:0] dz_list [6];
        aresetn = 0;
        cfg_valid = 0;
        cfg_data = '0;
        s_valid = 0;
        s_data = '0;
        cycle_count = 0;
        send_idle_pct = 21;
        recv_idle_pct = 61;
        dz_list = '{15'd0, 15'd32767, 15'd1, 15'd16384, 15'd30000, 15'd8192};
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, zero stick, both pads, triggers, button edges
        rep = '0;
        send_report(rep);
        rep = '{1'b1, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                16'sh8000, 16'sh7fff, 15'h7fff};
        send_report(rep);
        rep = '{1'b0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                16'sh7fff, 16'sh8000, 15'h5555};
        send_report(rep);
        rep = '{1'b1, 16'sd2000, 16'sd0, 16'sd0, -16'sd8192,
                16'sd0, -16'sd1, 15'h2aaa};
        send_report(rep);
        rep = '{1'b0, 16'sd8192, 16'sd0, 16'sd0, 16'sd8191,
                16'sd1, 16'sd0, 15'h0000};
        send_report(rep);
        write_dead_zone(15'd0);
        rep = '0;
        send_report(rep);
        rep = '{1'b1, 16'sd1, -16'sd1, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 15'h0001};
        send_report(rep);
        write_dead_zone(15'd32767);
        rep = '{1'b0, 16'sh7fff, 16'sh7fff, 16'sd30000, -16'sd20000,
                16'sd0, 16'sd0, 15'h4000};
        send_report(rep);
        rep = '{1'b0, 16'sh8000, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 15'h0};
        send_report(rep);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 21 : 0;
            for (int k = 0; k < 2; k++) begin
                write_dead_zone(dz_list[phase * 2 + k]);
                for (int n = 0; n < 110; n++) send_report(random_report());
            end
            write_dead_zone(15'($urandom));
            for (int n = 0; n < 110; n++) send_report(random_report());
        end

        while (pending_reports != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Covered %0d conditioned reports over eleven dead zone writes,",
                 report_count);
        $display("including zero and full-scale radius, both pads, random stalls.");
        if (fail_count == 0 && pending_reports == 0)
            $display("[gamepad_deadzone_and_button_edges] OK");
        else
            $display("[gamepad_deadzone_and_button_edges] ERROR");
        $finish;
    end
endmodule

/* filelist.f */
rtl/gdz_pkg.sv
rtl/gdz_dp.sv
rtl/gdz_ctrl.sv
rtl/gamepad_deadzone_and_button_edges.sv
rtl/gdz_chk.sv
bench/gdz_checker.sv
bench/testbench.sv
